### rtl/setbl_pkg.sv
// shared types and constants for the sorted edge table
package setbl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic        [9:0]  dest_vertex;
    logic signed [15:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
    logic [6:0] entry_count;
  } out_t;

  typedef struct packed {
    logic after;
    logic dup;
  } cell_flag_t;

endpackage

### rtl/setbl_cell.sv
// one table slot: holds an entry, compares it against a new beat, shifts on insert
module setbl_cell (
  input  logic                clk,
  input  logic                cmp_en,
  input  setbl_pkg::in_t      cmp_item,
  input  logic                ins_en,
  input  setbl_pkg::in_t      ins_item,
  input  logic                occ,
  input  logic                prev_after,
  input  setbl_pkg::in_t      prev_entry,
  output setbl_pkg::cell_flag_t flag,
  output setbl_pkg::in_t      entry
);

  setbl_pkg::in_t entry_r;
  logic           eq_r;
  logic           gt_r;
  logic           eq_nxt;
  logic           gt_nxt;

  always_comb begin
    eq_nxt = (cmp_item.dest_vertex == entry_r.dest_vertex) &&
             (cmp_item.edge_weight == entry_r.edge_weight);
    gt_nxt = (cmp_item.dest_vertex < entry_r.dest_vertex) ||
             ((cmp_item.dest_vertex == entry_r.dest_vertex) &&
              ($signed(cmp_item.edge_weight) < $signed(entry_r.edge_weight)));
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      eq_r <= eq_nxt;
      gt_r <= gt_nxt;
    end
    if (ins_en) begin
      if (prev_after) begin
        entry_r <= prev_entry;
      end else if (flag.after) begin
        entry_r <= ins_item;
      end
    end
  end

  assign flag.after = occ ? gt_r : 1'b1;
  assign flag.dup   = occ & eq_r;
  assign entry      = entry_r;

endmodule

### rtl/sorted_edge_table_insert.sv
// sorted edge table insert: top level with control, count and a row of slot cells
// At the accept edge every slot cell registers, in parallel, the compare of the new key
// against its stored entry. Then, in S_INS once the output register is free, the flags
// for duplicate and position are combined, the result goes to the output register and,
// on an insert, every slot above the new position takes its lower neighbor's entry while
// the slot at the new position takes the new edge, in one shift. The input is ready again
// only after that commit, so the block takes no new edge before the last one commits; a
// result that is not taken holds the commit until the output register frees. Entries are
// kept ascending by destination then signed weight; an exact duplicate returns status 1,
// a full table status 2, with slot 0 in both cases and the count unchanged.
module sorted_edge_table_insert #(
  parameter int unsigned CAPACITY = setbl_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  setbl_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output setbl_pkg::out_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_INS
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  setbl_pkg::in_t         item_r;
  setbl_pkg::out_t        out_r;
  setbl_pkg::out_t        out_nxt;
  logic                   out_valid_r;

  setbl_pkg::cell_flag_t  flags   [CAPACITY];
  setbl_pkg::in_t         entries [CAPACITY];
  logic [CAPACITY-1:0]    occ;
  logic [CAPACITY-1:0]    dup_vec;
  logic [CAPACITY-1:0]    ins_vec;

  logic                   in_acc;
  logic                   commit;
  logic                   dup;
  logic                   full;
  logic                   do_ins;
  logic [IW-1:0]          slot_idx;
  logic [1:0]             status;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign commit   = (state_r == S_INS) && (!out_valid_r || out_ready);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi]     = (count_r > CW'(gi));
      assign dup_vec[gi] = flags[gi].dup;
      if (gi == 0) begin : g_first
        assign ins_vec[gi] = flags[gi].after;
        setbl_cell u_cell (
          .clk        (clk),
          .cmp_en     (in_acc),
          .cmp_item   (in_data),
          .ins_en     (commit & do_ins),
          .ins_item   (item_r),
          .occ        (occ[gi]),
          .prev_after (1'b0),
          .prev_entry (item_r),
          .flag       (flags[gi]),
          .entry      (entries[gi])
        );
      end else begin : g_rest
        assign ins_vec[gi] = flags[gi].after & ~flags[gi-1].after;
        setbl_cell u_cell (
          .clk        (clk),
          .cmp_en     (in_acc),
          .cmp_item   (in_data),
          .ins_en     (commit & do_ins),
          .ins_item   (item_r),
          .occ        (occ[gi]),
          .prev_after (flags[gi-1].after),
          .prev_entry (entries[gi-1]),
          .flag       (flags[gi]),
          .entry      (entries[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_vec[i]) begin
        slot_idx = slot_idx | IW'(i);
      end
    end
  end

  assign dup    = |dup_vec;
  assign full   = (count_r == CW'(CAPACITY));
  assign do_ins = !dup && !full;

  always_comb begin
    priority if (dup) begin
      status = setbl_pkg::ST_DUPLICATE;
    end else if (full) begin
      status = setbl_pkg::ST_FULL;
    end else begin
      status = setbl_pkg::ST_INSERTED;
    end
    count_nxt               = do_ins ? count_r + CW'(1) : count_r;
    out_nxt.status          = status;
    out_nxt.slot            = do_ins ? 6'(slot_idx) : 6'd0;
    out_nxt.entry_count     = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          if (commit) begin
            state_r     <= S_IDLE;
            count_r     <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_acc) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an insert picks exactly one slot
  a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) && !full |-> $onehot(ins_vec))
    else $error("insert position not unique");

  // an insert raises the count by one, a reject leaves it
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> count_r == ($past(do_ins) ? $past(count_r) + CW'(1) : $past(count_r)))
    else $error("count update mismatch");

  // a commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

endmodule

### sim/sorted_edge_table_insert_tb.sv
// testbench for sorted_edge_table_insert: directed and random edges checked against a shadow table
`timescale 1ns / 100ps

module sorted_edge_table_insert_tb;
  import setbl_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // shadow copy of the table
  logic [9:0] shadow_dest[CAPACITY];
  logic signed [15:0] shadow_weight[CAPACITY];
  int shadow_count = 0;

  out_t pending_results[$];
  int fails = 0;
  int cnt_inserted = 0;
  int cnt_duplicate = 0;
  int cnt_full = 0;
  bit no_idle = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  sorted_edge_table_insert #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic out_t predict_insert(input logic [9:0] d, input logic signed [15:0] w);
    out_t r;
    int pos;
    bit dup;
    r = '0;
    dup = 1'b0;
    pos = shadow_count;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_dest[i] == d && shadow_weight[i] == w) dup = 1'b1;
    if (dup) begin
      r.status = ST_DUPLICATE;
    end else if (shadow_count >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      // first entry whose keys are strictly greater
      for (int i = shadow_count - 1; i >= 0; i--)
        if (d < shadow_dest[i] || (d == shadow_dest[i] && w < shadow_weight[i])) pos = i;
      for (int i = shadow_count; i > pos; i--) begin
        shadow_dest[i] = shadow_dest[i - 1];
        shadow_weight[i] = shadow_weight[i - 1];
      end
      shadow_dest[pos] = d;
      shadow_weight[pos] = w;
      shadow_count++;
      r.status = ST_INSERTED;
      r.slot = 6'(pos);
    end
    r.entry_count = 7'(shadow_count);
    return r;
  endfunction

  // caller is at a rising edge; returns at the edge where the beat is taken
  task automatic send_edge(input logic [9:0] d, input logic signed [15:0] w);
    out_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{dest_vertex: d, edge_weight: w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_insert(d, w);
    case (r.status)
      ST_INSERTED: cnt_inserted++;
      ST_DUPLICATE: cnt_duplicate++;
      default: cnt_full++;
    endcase
    pending_results.push_back(r);
  endtask

  task automatic random_key(output logic [9:0] d, output logic signed [15:0] w);
    case ($urandom_range(0, 3))
      0: d = (shadow_count > 0) ? shadow_dest[$urandom_range(0, shadow_count - 1)]
                                : 10'($urandom());
      1: d = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: d = 10'($urandom());
    endcase
    case ($urandom_range(0, 15))
      0: w = -16'sd32768;
      1: w = 16'sd32767;
      2: w = 16'sd0;
      default: w = 16'($urandom());
    endcase
  endtask

  task automatic send_stored_copy();
    int idx;
    idx = $urandom_range(0, shadow_count - 1);
    send_edge(shadow_dest[idx], shadow_weight[idx]);
  endtask

  task automatic send_random_fresh();
    logic [9:0] d;
    logic signed [15:0] w;
    random_key(d, w);
    send_edge(d, w);
  endtask

  task automatic test_extreme_keys();
    send_edge(10'd512, 16'sd0);
    send_edge(10'd1023, 16'sd32767);
    send_edge(10'd0, -16'sd32768);
    send_edge(10'd512, -16'sd1);
    send_edge(10'd512, 16'sd1);
    send_edge(10'd512, 16'sd0);
    send_edge(10'd0, 16'sd32767);
    send_edge(10'd1023, -16'sd32768);
    send_edge(10'd1023, 16'sd32767);
    send_edge(10'd0, -16'sd32768);
    send_edge(10'd511, 16'sd0);
    send_edge(10'd513, 16'sd0);
    send_edge(10'd341, 16'sh5555);
    send_edge(10'd682, -16'sh5556);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_stall();
    hold_req <= 1'b1;
    repeat (24) begin
      if ($urandom_range(0, 2) == 0) send_stored_copy();
      else send_random_fresh();
    end
  endtask

  task automatic test_gradual_growth();
    for (int k = 0; k < 620; k++) begin
      no_idle = (k >= 200 && k < 300);
      if (shadow_count == 0 || $urandom_range(0, 9) == 0) send_random_fresh();
      else send_stored_copy();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_fill_to_capacity();
    while (shadow_count < CAPACITY) send_random_fresh();
  endtask

  task automatic test_full_table();
    send_edge(shadow_dest[0], shadow_weight[0]);
    send_edge(shadow_dest[CAPACITY - 1], shadow_weight[CAPACITY - 1]);
    send_edge(10'd1023, 16'sd32766);
    send_edge(10'd0, -16'sd32767);
    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(0, 1) == 0) send_stored_copy();
      else send_random_fresh();
    end
  endtask

  always @(posedge clk) begin : ready_drive
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      gap = pick_gap();
      if (gap > 0 && $urandom_range(0, 2) == 0) begin
        hold_left = gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: %p", out_data);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fails++;
        end
        if (out_data.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
          fails++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_data.entry_count);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_extreme_keys();
    test_output_stall();
    test_gradual_growth();
    test_fill_to_capacity();
    test_full_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("edges sent: %0d inserted, %0d duplicate, %0d rejected on a full table",
             cnt_inserted, cnt_duplicate, cnt_full);
    $display("table grew from empty to %0d entries, including a long output stall",
             shadow_count);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/setbl_pkg.sv
rtl/setbl_cell.sv
rtl/sorted_edge_table_insert.sv
sim/sorted_edge_table_insert_tb.sv
